### src/assert_macros.svh
//------------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the block's checkers.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### src/bbp_pkg.sv
//------------------------------------------------------------------------------
// Bimodal branch predictor package
// Sizes, codes, shared types and helpers of the predictor.
//------------------------------------------------------------------------------
package bbp_pkg;

   localparam int INDEX_BITS_MAX = 12;
   localparam int COUNT_BITS     = 32;
   localparam int TABLE_DEPTH    = 1 << INDEX_BITS_MAX;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_BITS        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CTR_INIT        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPORT_INTERVAL = 2'd2;

   localparam logic OP_RESOLVE = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;

   localparam logic [1:0] CTR_MAX = 2'd3;
   localparam logic [1:0] CTR_MIN = 2'd0;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic resolve;
      logic clear;
      logic miss;
   } stats_upd_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] total_branches;
      logic [COUNT_BITS-1:0] total_misses;
      logic                  interval_done;
      logic [COUNT_BITS-1:0] interval_misses;
   } stats_res_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

### src/bimodal_branch_predictor.sv
//------------------------------------------------------------------------------
// Bimodal branch predictor
// Two-bit saturating counters indexed by low PC bits, with miss statistics.
//------------------------------------------------------------------------------
// A beat is taken only in the idle state, after the previous beat has left the
// update stage: the accepting edge reads the counter memory (4096 x 3 bits, a
// written flag and the counter, synchronous read) into a read register, and the
// update stage then updates the counter, writes it back on a branch beat and loads the result register.
// A beat holds in the update stage while a stalled result occupies the result
// register, and no new beat is taken until that stage has moved on. A clear
// beat returns an all-zero result. After reset, and after every clear beat, a
// clearing pass writes all 4096 entries, one per cycle, so the block takes no
// beat until that pass is done. Configuration writes are taken at any time and act on
// a beat already taken, so write them while no beat is in flight.
// Configuration: index 0 index bit count, 1 initial counter value,
// 2 report interval.
//------------------------------------------------------------------------------
module bimodal_branch_predictor
   import bbp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_op,
   input  logic [63:0]            req_pc,
   input  logic                   req_taken,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_predicted_taken,
   output logic                   rsp_mispredicted,
   output logic [COUNT_BITS-1:0]  rsp_total_branches,
   output logic [COUNT_BITS-1:0]  rsp_total_misses,
   output logic                   rsp_interval_done,
   output logic [COUNT_BITS-1:0]  rsp_interval_misses,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   state_type state_ff, state_in;

   logic [3:0]            idx_bits_ff;
   logic [1:0]            ctr_init_ff;
   logic [COUNT_BITS-1:0] report_interval_ff;

   logic [INDEX_BITS_MAX-1:0] sweep_addr_ff, sweep_addr_in;
   logic                      op_ff;
   logic                      taken_ff;
   logic [INDEX_BITS_MAX-1:0] idx_ff;

   logic [2:0] table_mem [TABLE_DEPTH];
   logic [2:0] rd_data_ff;
   logic       mem_rd_en;
   logic       mem_wr_en;
   logic [INDEX_BITS_MAX-1:0] mem_wr_addr;
   logic [2:0] mem_wr_data;

   logic [INDEX_BITS_MAX-1:0] idx_mask;
   logic [INDEX_BITS_MAX-1:0] req_idx;
   logic [1:0] ctr;
   logic [1:0] ctr_next;
   logic       pred;
   logic       miss;
   logic       out_free;
   logic       rsp_load;

   stats_upd_type upd;
   stats_res_type stats_res;

   logic                  rsp_valid_ff;
   logic                  rsp_pred_ff;
   logic                  rsp_miss_ff;
   stats_res_type         rsp_stats_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_bits_ff        <= 4'd12;
         ctr_init_ff        <= 2'd1;
         report_interval_ff <= 32'd1000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IDX_BITS:        idx_bits_ff        <= csr_data[3:0];
            CSR_CTR_INIT:        ctr_init_ff        <= csr_data[1:0];
            CSR_REPORT_INTERVAL: report_interval_ff <= csr_data[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < INDEX_BITS_MAX; i++) begin
         idx_mask[i] = (i < int'(idx_bits_ff));
      end
      req_idx = req_pc[INDEX_BITS_MAX-1:0] & idx_mask;
   end

   always_comb begin
      ctr  = rd_data_ff[2] ? rd_data_ff[1:0] : ctr_init_ff;
      pred = ctr[1];
      miss = pred != taken_ff;
      if (taken_ff) begin
         ctr_next = (ctr == CTR_MAX) ? ctr : ctr + 2'd1;
      end else begin
         ctr_next = (ctr == CTR_MIN) ? ctr : ctr - 2'd1;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      req_stall     = 1'b1;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff;
      mem_wr_data   = {1'b1, ctr_next};
      rsp_load      = 1'b0;
      upd           = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = sweep_addr_ff;
            mem_wr_data   = '0;
            sweep_addr_in = sweep_addr_ff + 1'b1;
            if (sweep_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mem_rd_en = 1'b1;
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (op_ff == OP_CLEAR) begin
                  upd.clear = 1'b1;
                  state_in  = ST_SWEEP;
               end else begin
                  upd.resolve = 1'b1;
                  upd.miss    = miss;
                  mem_wr_en   = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: state_in = ST_SWEEP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         op_ff    <= req_op;
         taken_ff <= req_taken;
         idx_ff   <= req_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         table_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= table_mem[req_idx];
      end
   end

   bbp_stats u_stats (
      .clock           (clock),
      .reset           (reset),
      .report_interval (report_interval_ff),
      .upd             (upd),
      .res             (stats_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pred_ff  <= upd.resolve & pred;
         rsp_miss_ff  <= upd.resolve & miss;
         rsp_stats_ff <= stats_res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_taken = rsp_pred_ff;
   assign rsp_mispredicted    = rsp_miss_ff;
   assign rsp_total_branches  = rsp_stats_ff.total_branches;
   assign rsp_total_misses    = rsp_stats_ff.total_misses;
   assign rsp_interval_done   = rsp_stats_ff.interval_done;
   assign rsp_interval_misses = rsp_stats_ff.interval_misses;

endmodule

### src/bbp_stats.sv
//------------------------------------------------------------------------------
// Predictor statistics
// Saturating branch and miss counts since clear, and interval miss reports.
//------------------------------------------------------------------------------
module bbp_stats
   import bbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COUNT_BITS-1:0] report_interval,
   input  stats_upd_type         upd,
   output stats_res_type         res
);

   logic [COUNT_BITS-1:0] branch_ff, branch_in;
   logic [COUNT_BITS-1:0] miss_ff, miss_in;
   logic [COUNT_BITS-1:0] ipos_ff, ipos_in;
   logic [COUNT_BITS-1:0] imiss_ff, imiss_in;

   logic [COUNT_BITS-1:0] branch_inc;
   logic [COUNT_BITS-1:0] miss_new;
   logic [COUNT_BITS-1:0] ipos_inc;
   logic [COUNT_BITS-1:0] imiss_new;
   logic                  done;

   always_comb begin
      branch_inc = sat_inc(branch_ff);
      miss_new   = upd.miss ? sat_inc(miss_ff) : miss_ff;
      imiss_new  = upd.miss ? sat_inc(imiss_ff) : imiss_ff;
      ipos_inc   = sat_inc(ipos_ff);
      done       = (report_interval != '0) && (ipos_inc >= report_interval);

      branch_in = branch_ff;
      miss_in   = miss_ff;
      ipos_in   = ipos_ff;
      imiss_in  = imiss_ff;
      res       = '0;

      if (upd.clear) begin
         branch_in = '0;
         miss_in   = '0;
         ipos_in   = '0;
         imiss_in  = '0;
      end else if (upd.resolve) begin
         branch_in = branch_inc;
         miss_in   = miss_new;
         ipos_in   = done ? '0 : ipos_inc;
         imiss_in  = done ? '0 : imiss_new;
         res.total_branches  = branch_inc;
         res.total_misses    = miss_new;
         res.interval_done   = done;
         res.interval_misses = done ? imiss_new : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         branch_ff <= '0;
         miss_ff   <= '0;
         ipos_ff   <= '0;
         imiss_ff  <= '0;
      end else begin
         branch_ff <= branch_in;
         miss_ff   <= miss_in;
         ipos_ff   <= ipos_in;
         imiss_ff  <= imiss_in;
      end
   end

endmodule

### src/bbp_checker.sv
//------------------------------------------------------------------------------
// Predictor checker
// Port-level checks on the result channel, bound to the top level.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module bbp_checker
   import bbp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_mispredicted,
   input logic [COUNT_BITS-1:0] rsp_total_branches,
   input logic [COUNT_BITS-1:0] rsp_total_misses,
   input logic                  rsp_interval_done,
   input logic [COUNT_BITS-1:0] rsp_interval_misses
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   `ASSERT_IMPL(a_misses_bounded, clock, reset, rsp_valid, rsp_total_misses <= rsp_total_branches)

   `ASSERT_IMPL(a_no_report_zero, clock, reset, rsp_valid && !rsp_interval_done, rsp_interval_misses == '0)

   `ASSERT_IMPL(a_interval_bounded, clock, reset, rsp_valid && rsp_interval_done, rsp_interval_misses <= rsp_total_misses)

   `ASSERT_IMPL(a_miss_counted, clock, reset, rsp_valid && rsp_mispredicted, rsp_total_misses != '0)

endmodule

bind bimodal_branch_predictor bbp_checker u_checker (.*);

### bench/tb_bimodal_branch_predictor.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Bimodal branch predictor testbench
// Drives branch and clear beats with random gaps and result stalls, keeps its
// own model of the counter table, statistics and registers, and compares every
// result beat field by field against the oldest pending prediction.
//------------------------------------------------------------------------------
module tb_bimodal_branch_predictor;
   import bbp_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PRINT_LIMIT = 40;

   typedef struct {
      logic                  predicted_taken;
      logic                  mispredicted;
      logic [COUNT_BITS-1:0] total_branches;
      logic [COUNT_BITS-1:0] total_misses;
      logic                  interval_done;
      logic [COUNT_BITS-1:0] interval_misses;
   } branch_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_op;
   logic [63:0]            req_pc;
   logic                   req_taken;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_predicted_taken;
   logic                   rsp_mispredicted;
   logic [COUNT_BITS-1:0]  rsp_total_branches;
   logic [COUNT_BITS-1:0]  rsp_total_misses;
   logic                   rsp_interval_done;
   logic [COUNT_BITS-1:0]  rsp_interval_misses;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_data;

   // predictor model state and registers
   logic [1:0]            counter_model [TABLE_DEPTH];
   logic                  written_model [TABLE_DEPTH];
   logic [COUNT_BITS-1:0] branch_total;
   logic [COUNT_BITS-1:0] miss_total;
   logic [COUNT_BITS-1:0] interval_pos;
   logic [COUNT_BITS-1:0] interval_miss;
   logic [3:0]            idx_bits_reg;
   logic [1:0]            ctr_init_reg;
   logic [31:0]           interval_reg;

   branch_result_type pending_results [$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  branch_beats = 0;
   int  clear_beats = 0;
   int  csr_writes = 0;
   int  interval_reports = 0;
   int  stall_left = 0;
   bit  quiet = 1'b0;

   bimodal_branch_predictor dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_pc              (req_pc),
      .req_taken           (req_taken),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_predicted_taken (rsp_predicted_taken),
      .rsp_mispredicted    (rsp_mispredicted),
      .rsp_total_branches  (rsp_total_branches),
      .rsp_total_misses    (rsp_total_misses),
      .rsp_interval_done   (rsp_interval_done),
      .rsp_interval_misses (rsp_interval_misses),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_results.size());
         $display("tb_bimodal_branch_predictor: errors");
         $finish;
      end
   end

   function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] v);
      return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic forget_table();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         written_model[i] = 1'b0;
         counter_model[i] = 2'd0;
      end
      branch_total  = '0;
      miss_total    = '0;
      interval_pos  = '0;
      interval_miss = '0;
   endtask

   task automatic predict_beat(input logic op, input logic [63:0] pc, input logic taken);
      branch_result_type r;
      int unsigned nbits;
      logic [INDEX_BITS_MAX-1:0] idx;
      logic [1:0] ctr;
      r = '{default: '0};
      if (op == OP_CLEAR) begin
         forget_table();
         clear_beats++;
      end else begin
         nbits = (idx_bits_reg > INDEX_BITS_MAX) ? INDEX_BITS_MAX : idx_bits_reg;
         idx = pc[INDEX_BITS_MAX-1:0] & ~({INDEX_BITS_MAX{1'b1}} << nbits);
         ctr = written_model[idx] ? counter_model[idx] : ctr_init_reg;
         r.predicted_taken = (ctr >= 2'd2);
         r.mispredicted = (r.predicted_taken != taken);
         if (taken && ctr != CTR_MAX) ctr = ctr + 2'd1;
         else if (!taken && ctr != CTR_MIN) ctr = ctr - 2'd1;
         counter_model[idx] = ctr;
         written_model[idx] = 1'b1;
         branch_total = count_up(branch_total);
         if (r.mispredicted) begin
            miss_total = count_up(miss_total);
            interval_miss = count_up(interval_miss);
         end
         interval_pos = count_up(interval_pos);
         if (interval_reg != 0 && interval_pos >= interval_reg) begin
            r.interval_done = 1'b1;
            r.interval_misses = interval_miss;
            interval_pos = '0;
            interval_miss = '0;
            interval_reports++;
         end
         r.total_branches = branch_total;
         r.total_misses = miss_total;
         branch_beats++;
      end
      pending_results.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch on %s: got %0h, want %0h (cycle %0d)", what, got, want,
                  cycle_count);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : rsp_checker
      branch_result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat", 32'd1, 32'd0);
         end else begin
            want = pending_results.pop_front();
            check_field("predicted_taken", 32'(rsp_predicted_taken),
                        32'(want.predicted_taken));
            check_field("mispredicted", 32'(rsp_mispredicted), 32'(want.mispredicted));
            check_field("total_branches", rsp_total_branches, want.total_branches);
            check_field("total_misses", rsp_total_misses, want.total_misses);
            check_field("interval_done", 32'(rsp_interval_done),
                        32'(want.interval_done));
            check_field("interval_misses", rsp_interval_misses, want.interval_misses);
         end
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
            if (!quiet && $urandom_range(0, 5) == 0) stall_left = pick_gap();
         end
      end
   end

   // call at a falling edge; returns at a falling edge after the beat and any random gap
   task automatic send_beat(input logic op, input logic [63:0] pc, input logic taken);
      int gap;
      req_valid = 1'b1;
      req_op    = op;
      req_pc    = pc;
      req_taken = taken;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_beat(op, pc, taken);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_IDX_BITS:        idx_bits_reg = data[3:0];
         CSR_CTR_INIT:        ctr_init_reg = data[1:0];
         CSR_REPORT_INTERVAL: interval_reg = data;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_reset_values();
      send_beat(OP_RESOLVE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_beat(OP_RESOLVE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_beat(OP_RESOLVE, 64'h0, 1'b1);
      send_beat(OP_RESOLVE, 64'h0, 1'b1);
      send_beat(OP_RESOLVE, 64'h0, 1'b1);
   endtask

   task automatic test_index_bits();
      wait_idle();
      csr_write(CSR_IDX_BITS, 32'd0);
      send_beat(OP_RESOLVE, 64'h5, 1'b1);
      send_beat(OP_RESOLVE, 64'hA, 1'b1);
      wait_idle();
      csr_write(CSR_IDX_BITS, 32'd15);
      send_beat(OP_RESOLVE, 64'hFFFF_FFFF_FFFF_F123, 1'b0);
      wait_idle();
      csr_write(CSR_IDX_BITS, 32'd13);
      send_beat(OP_RESOLVE, 64'h1FFF, 1'b1);
      wait_idle();
      csr_write(CSR_IDX_BITS, 32'd1);
      send_beat(OP_RESOLVE, 64'h3, 1'b1);
   endtask

   task automatic test_ctr_init();
      wait_idle();
      csr_write(CSR_IDX_BITS, 32'd12);
      csr_write(CSR_CTR_INIT, 32'd3);
      send_beat(OP_CLEAR, {$urandom, $urandom}, 1'($urandom));
      send_beat(OP_RESOLVE, 64'h77, 1'b0);
      wait_idle();
      csr_write(CSR_CTR_INIT, 32'd0);
      send_beat(OP_RESOLVE, 64'h78, 1'b1);
   endtask

   task automatic test_report_interval();
      wait_idle();
      csr_write(CSR_REPORT_INTERVAL, 32'd1);
      send_beat(OP_RESOLVE, 64'h100, 1'b1);
      send_beat(OP_RESOLVE, 64'h100, 1'b0);
      wait_idle();
      csr_write(CSR_REPORT_INTERVAL, 32'd0);
      send_beat(OP_RESOLVE, 64'h101, 1'b1);
      send_beat(OP_RESOLVE, 64'h102, 1'b0);
      wait_idle();
      csr_write(CSR_REPORT_INTERVAL, 32'hFFFF_FFFF);
      send_beat(OP_RESOLVE, 64'h103, 1'b1);
      wait_idle();
      csr_write(CSR_REPORT_INTERVAL, 32'd20);
      send_beat(OP_RESOLVE, 64'h104, 1'b1);
      send_beat(OP_RESOLVE, 64'h104, 1'b1);
      send_beat(OP_RESOLVE, 64'h105, 1'b0);
      wait_idle();
      // lower below the current position
      csr_write(CSR_REPORT_INTERVAL, 32'd2);
      send_beat(OP_RESOLVE, 64'h106, 1'b1);
   endtask

   task automatic test_random_traffic();
      logic [63:0] pc_pool [8];
      int          bias [8];
      int          r;
      int          k;
      int          n_items;
      logic [31:0] ivl;
      for (int phase = 0; phase < 10; phase++) begin
         wait_idle();
         quiet = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 9);
         if (r == 0) csr_write(CSR_IDX_BITS, 32'd0);
         else if (r == 1) csr_write(CSR_IDX_BITS, $urandom_range(13, 15));
         else csr_write(CSR_IDX_BITS, $urandom_range(1, 12));
         csr_write(CSR_CTR_INIT, $urandom_range(0, 3));
         r = $urandom_range(0, 9);
         if (r < 4) ivl = $urandom_range(1, 16);
         else if (r == 4) ivl = 32'd0;
         else if (r == 5) ivl = $urandom;
         else if (r == 6) ivl = 32'hFFFF_FFFF;
         else ivl = $urandom_range(17, 200);
         csr_write(CSR_REPORT_INTERVAL, ivl);
         for (int i = 0; i < 8; i++) begin
            pc_pool[i] = {$urandom, $urandom};
            r = $urandom_range(0, 2);
            bias[i] = (r == 0) ? 5 : (r == 1) ? 50 : 95;
         end
         n_items = $urandom_range(60, 80);
         for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 999);
            if (r < 15) begin
               send_beat(OP_CLEAR, {$urandom, $urandom}, 1'($urandom));
            end else if (r < 800) begin
               k = $urandom_range(0, 7);
               send_beat(OP_RESOLVE, pc_pool[k], $urandom_range(0, 99) < bias[k]);
            end else begin
               send_beat(OP_RESOLVE, {$urandom, $urandom}, 1'($urandom));
            end
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_op    = OP_RESOLVE;
      req_pc    = '0;
      req_taken = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_IDX_BITS;
      csr_data  = '0;
      forget_table();
      idx_bits_reg = 4'd12;
      ctr_init_reg = 2'd1;
      interval_reg = 32'd1000;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_index_bits();
      test_ctr_init();
      test_report_interval();
      test_random_traffic();

      req_valid = 1'b0;
      for (int n = 0; n < 5000 && pending_results.size() != 0; n++) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", 32'(pending_results.size()), 32'd0);
      repeat (8) @(posedge clock);

      $display("ran %0d branch beats and %0d clear beats over %0d register writes,",
               branch_beats, clear_beats, csr_writes);
      $display("saw %0d interval reports, %0d mismatches", interval_reports, error_count);
      if (error_count == 0) begin
         $display("tb_bimodal_branch_predictor: clean");
      end else begin
         $display("tb_bimodal_branch_predictor: errors");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/bbp_pkg.sv
src/bbp_stats.sv
src/bimodal_branch_predictor.sv
src/bbp_checker.sv
bench/tb_bimodal_branch_predictor.sv
